>>> rtl/cacfr_pkg.sv
// Shared types for the clockwise arc center block.
package cacfr_pkg;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL1, ST_FORM, ST_SQRT, ST_PREP2, ST_MUL2, ST_FORMN, ST_DIV, ST_DONE
  } cacfr_state_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MUL1, OP_FORM, OP_SQRT, OP_PREP2, OP_MUL2, OP_FORMN, OP_DIV,
    OP_DONE
  } cacfr_op_e;

  typedef struct packed {
    cacfr_op_e op;
    logic      out_load;
  } cacfr_cmd_t;

endpackage

>>> rtl/cacfr_if.sv
// Valid/ready channel interfaces for arc end points and arc centers.
interface cacfr_in_if #(parameter int CB = 32) ();
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] end_x;
  logic signed [CB-1:0] end_y;
  logic [CB-2:0]        radius;
  modport source (output valid, end_x, end_y, radius, input ready);
  modport sink (input valid, end_x, end_y, radius, output ready);
endinterface

interface cacfr_out_if #(parameter int CB = 32) ();
  logic                 valid;
  logic                 ready;
  logic signed [CB-1:0] center_x;
  logic signed [CB-1:0] center_y;
  logic                 radius_too_small;
  modport source (output valid, center_x, center_y, radius_too_small, input ready);
  modport sink (input valid, center_x, center_y, radius_too_small, output ready);
endinterface

>>> rtl/clockwise_arc_center_from_radius_top.sv
// Top level: clockwise (G02) arc center from end point and radius.
// One word at a time: a new word is taken only after the last center is loaded for output;
//   the multiply, root and divide iterations of the shared datapath run one bit or one
//   root digit per cycle.
// Reset (async, active low): sequencer idle, no output word, previous point (4.0, 4.0).
// The finished center waits in the output register while the next word is taken.
module clockwise_arc_center_from_radius_top #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic clk_i,
  input logic rst_ni,
  cacfr_in_if.sink    in_i,
  cacfr_out_if.source out_o
);
  import cacfr_pkg::*;

  cacfr_cmd_t cmd;

  // sequencer: steps the datapath through multiply, root, multiply, divide
  cacfr_ctrl #(.CB(COORD_BITS)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  // datapath: holds the previous point and the output word
  cacfr_dp #(.CB(COORD_BITS), .FB(FRAC_BITS)) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .end_x_i            (in_i.end_x),
    .end_y_i            (in_i.end_y),
    .radius_i           (in_i.radius),
    .center_x_o         (out_o.center_x),
    .center_y_o         (out_o.center_y),
    .radius_too_small_o (out_o.radius_too_small)
  );

endmodule

>>> rtl/cacfr_ctrl.sv
// Sequencer for the arc center datapath.
module cacfr_ctrl #(
  parameter int CB = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output cacfr_pkg::cacfr_cmd_t cmd_o
);
  import cacfr_pkg::*;

  localparam int DW   = CB + 1;
  localparam int SW   = CB + 2;
  localparam int NW   = 2 * CB + 4;
  localparam int CNTW = $clog2(NW + 1);

  cacfr_state_e state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d;
  logic out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and iteration count
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_MUL1;
          cnt_d   = CNTW'(DW - 1);
        end
      end
      ST_MUL1: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_FORM;
      end
      ST_FORM: begin
        state_d = ST_SQRT;
        cnt_d   = CNTW'(SW - 1);
      end
      ST_SQRT: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_PREP2;
      end
      ST_PREP2: begin
        state_d = ST_MUL2;
        cnt_d   = CNTW'(SW - 1);
      end
      ST_MUL2: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_FORMN;
      end
      ST_FORMN: begin
        state_d = ST_DIV;
        cnt_d   = CNTW'(NW - 1);
      end
      ST_DIV: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // commands and handshake outputs
  always_comb begin
    cmd_o.op       = OP_NONE;
    cmd_o.out_load = 1'b0;
    out_valid_d    = out_valid_q && !out_ready_i;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) cmd_o.op = OP_LOAD;
      ST_MUL1:  cmd_o.op = OP_MUL1;
      ST_FORM:  cmd_o.op = OP_FORM;
      ST_SQRT:  cmd_o.op = OP_SQRT;
      ST_PREP2: cmd_o.op = OP_PREP2;
      ST_MUL2:  cmd_o.op = OP_MUL2;
      ST_FORMN: cmd_o.op = OP_FORMN;
      ST_DIV:   cmd_o.op = OP_DIV;
      ST_DONE: begin
        if (out_free) begin
          cmd_o.op       = OP_DONE;
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/cacfr_dp.sv
// Datapath: shift-add multipliers, digit square roots and restoring dividers.
module cacfr_dp #(
  parameter int CB = 32,
  parameter int FB = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cacfr_pkg::cacfr_cmd_t cmd_i,
  input  logic signed [CB-1:0]  end_x_i,
  input  logic signed [CB-1:0]  end_y_i,
  input  logic [CB-2:0]         radius_i,
  output logic signed [CB-1:0]  center_x_o,
  output logic signed [CB-1:0]  center_y_o,
  output logic                  radius_too_small_o
);
  import cacfr_pkg::*;

  localparam int DW  = CB + 1;
  localparam int PW  = 2 * DW;
  localparam int SW  = CB + 2;
  localparam int RW  = 2 * SW;
  localparam int MW  = SW + 2;
  localparam int NW  = 2 * CB + 4;
  localparam int VW  = SW + 1;
  localparam logic [CB-1:0] PREV_RST = CB'(4) << FB;
  localparam logic [NW-1:0] QPOS = (NW'(1) << (CB - 1)) - NW'(1);
  localparam logic [NW-1:0] QNEG = NW'(1) << (CB - 1);
  localparam logic [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};

  logic [CB-1:0] px_q, py_q;
  logic signed [DW-1:0] dx_q, dy_q, sx_q, sy_q;
  logic [PW-1:0] mc1_q [3];
  logic [DW-1:0] mp1_q [3];
  logic [PW-1:0] pr1_q [3];
  logic err_q, zero_q;
  logic [RW-1:0] rad_q [2];
  logic [MW-1:0] rem_q [2];
  logic [SW-1:0] root_q [2];
  logic [SW-1:0] s_q;
  logic [NW-1:0] mc2_q [4];
  logic [SW-1:0] mp2_q [4];
  logic [NW-1:0] pr2_q [4];
  logic [NW-1:0] dq_q [2];
  logic [VW-1:0] drem_q [2];
  logic neg_q [2];
  logic [VW-1:0] dv;

  logic signed [DW-1:0] dx_n, dy_n;
  logic [PW:0] d2, r4;
  logic [CB-1:0] sat [2];

  assign dx_n = DW'(end_x_i) - DW'(signed'(px_q));
  assign dy_n = DW'(end_y_i) - DW'(signed'(py_q));
  assign d2   = {1'b0, pr1_q[0]} + {1'b0, pr1_q[1]};
  assign r4   = {pr1_q[2][PW-2:0], 2'b00};
  assign dv   = {s_q, 1'b0};

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    return v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  // hold the previous point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q <= PREV_RST;
      py_q <= PREV_RST;
    end else if (cmd_i.op == OP_LOAD) begin
      px_q <= end_x_i;
      py_q <= end_y_i;
    end
  end

  always_ff @(posedge clk_i) begin
    logic [MW+1:0] tmp;
    logic [MW+1:0] trial;
    logic [NW-1:0] n;
    logic [VW:0]   dt;
    unique case (cmd_i.op)
      OP_LOAD: begin
        dx_q <= dx_n;
        dy_q <= dy_n;
        sx_q <= DW'(end_x_i) + DW'(signed'(px_q));
        sy_q <= DW'(end_y_i) + DW'(signed'(py_q));
        mc1_q[0] <= PW'(mag(dx_n));
        mp1_q[0] <= mag(dx_n);
        mc1_q[1] <= PW'(mag(dy_n));
        mp1_q[1] <= mag(dy_n);
        mc1_q[2] <= PW'(radius_i);
        mp1_q[2] <= DW'(radius_i);
        for (int k = 0; k < 3; k++) pr1_q[k] <= '0;
      end
      OP_MUL1: begin
        for (int k = 0; k < 3; k++) begin
          if (mp1_q[k][0]) pr1_q[k] <= pr1_q[k] + mc1_q[k];
          mc1_q[k] <= mc1_q[k] << 1;
          mp1_q[k] <= mp1_q[k] >> 1;
        end
      end
      OP_FORM: begin
        zero_q   <= (d2 == '0);
        err_q    <= (d2 != '0) && (r4 < d2);
        rad_q[0] <= RW'(d2);
        rad_q[1] <= ((d2 == '0) || (r4 < d2)) ? '0 : RW'(r4 - d2);
        for (int k = 0; k < 2; k++) begin
          rem_q[k]  <= '0;
          root_q[k] <= '0;
        end
      end
      OP_SQRT: begin
        for (int k = 0; k < 2; k++) begin
          tmp   = {rem_q[k], rad_q[k][RW-1:RW-2]};
          trial = (MW+2)'({root_q[k], 2'b01});
          if (tmp >= trial) begin
            rem_q[k]  <= MW'(tmp - trial);
            root_q[k] <= {root_q[k][SW-2:0], 1'b1};
          end else begin
            rem_q[k]  <= MW'(tmp);
            root_q[k] <= {root_q[k][SW-2:0], 1'b0};
          end
          rad_q[k] <= rad_q[k] << 2;
        end
      end
      OP_PREP2: begin
        s_q      <= zero_q ? SW'(1) : root_q[0];
        mc2_q[0] <= NW'(sx_q);
        mc2_q[1] <= NW'(sy_q);
        mc2_q[2] <= NW'(dy_q);
        mc2_q[3] <= NW'(dx_q);
        mp2_q[0] <= zero_q ? SW'(1) : root_q[0];
        mp2_q[1] <= zero_q ? SW'(1) : root_q[0];
        mp2_q[2] <= root_q[1];
        mp2_q[3] <= root_q[1];
        for (int k = 0; k < 4; k++) pr2_q[k] <= '0;
      end
      OP_MUL2: begin
        for (int k = 0; k < 4; k++) begin
          if (mp2_q[k][0]) pr2_q[k] <= pr2_q[k] + mc2_q[k];
          mc2_q[k] <= mc2_q[k] << 1;
          mp2_q[k] <= mp2_q[k] >> 1;
        end
      end
      OP_FORMN: begin
        for (int k = 0; k < 2; k++) begin
          n = (k == 0) ? pr2_q[0] + pr2_q[2] + NW'(s_q)
                       : pr2_q[1] - pr2_q[3] + NW'(s_q);
          neg_q[k]  <= n[NW-1];
          // floor toward -inf: divide magnitude plus divisor minus one
          dq_q[k]   <= n[NW-1] ? (-n) + NW'(dv) - NW'(1) : n;
          drem_q[k] <= '0;
        end
      end
      OP_DIV: begin
        for (int k = 0; k < 2; k++) begin
          dt = {drem_q[k], dq_q[k][NW-1]};
          if (dt >= (VW+1)'(dv)) begin
            drem_q[k] <= VW'(dt - (VW+1)'(dv));
            dq_q[k]   <= {dq_q[k][NW-2:0], 1'b1};
          end else begin
            drem_q[k] <= VW'(dt);
            dq_q[k]   <= {dq_q[k][NW-2:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  // saturate the quotients to the coordinate range
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (!neg_q[k]) sat[k] = (dq_q[k] > QPOS) ? CMAX : dq_q[k][CB-1:0];
      else sat[k] = (dq_q[k] > QNEG) ? CMIN : CB'(-dq_q[k][CB-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      center_x_o         <= sat[0];
      center_y_o         <= sat[1];
      radius_too_small_o <= err_q;
    end
  end

endmodule

>>> rtl/cacfr_chk.sv
// Port-level checks for the arc center block.
module cacfr_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output word dropped while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  a_no_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("output word too early");

  a_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("output word without work");

endmodule

bind clockwise_arc_center_from_radius_top cacfr_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready)
);

>>> test/clockwise_arc_center_from_radius_top_test.sv
// Self-checking testbench for the clockwise arc center block: directed and random end points.
`timescale 1ns / 100ps

module clockwise_arc_center_from_radius_top_test;

  localparam int CB        = 32;
  localparam int FB        = 16;
  // Allowance per word, used by the watchdog and the final drain.
  localparam int LATENCY   = 5 * CB + 14;
  // Cycles without any accepted word before the run is declared hung. The worst
  // case is one full compute plus the longest sink stall; take it many times over.
  localparam int HANG_LIMIT = 20 * (LATENCY + 8);
  localparam int N_RANDOM  = 2000;
  // Near the end of the run both sides stop idling.
  localparam int CALM_TAIL = 200;

  typedef struct {
    logic signed [CB-1:0] end_x;
    logic signed [CB-1:0] end_y;
    logic [CB-2:0]        radius;
  } arc_cmd_t;

  typedef struct {
    logic signed [CB-1:0] center_x;
    logic signed [CB-1:0] center_y;
    logic                 radius_too_small;
  } arc_center_t;

  logic clk;
  logic rst_n;

  cacfr_in_if  #(.CB(CB)) cmd_ch ();
  cacfr_out_if #(.CB(CB)) center_ch ();

  clockwise_arc_center_from_radius_top #(
    .COORD_BITS(CB),
    .FRAC_BITS (FB)
  ) u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (cmd_ch),
    .out_o (center_ch)
  );

  // Free-running clock, 10 ns period.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  arc_cmd_t    pending_cmds[$];
  arc_center_t expected_centers[$];

  // Predictor state: the start point of the next arc.
  logic signed [CB-1:0] start_x;
  logic signed [CB-1:0] start_y;

  int  n_failures;
  int  n_sent;
  int  n_total;
  int  n_centers;
  int  n_too_small;
  int  n_coincident;
  bit  calm;

  // Floor of the square root, wide enough for a 67-bit chord square.
  function automatic logic [127:0] floor_root(logic [127:0] n);
    logic [127:0] res;
    logic [127:0] trial;
    res = '0;
    for (int i = 40; i >= 0; i--) begin
      trial = res | (128'd1 << i);
      if (trial * trial <= n) res = trial;
    end
    return res;
  endfunction

  // Floor division of a signed numerator, clamped to the coordinate range.
  function automatic logic signed [CB-1:0] floor_div_clamp(logic signed [127:0] n,
                                                           logic signed [127:0] dv);
    logic signed [127:0] quo;
    quo = n / dv;
    if (n < 0 && (n % dv) != 0) quo = quo - 1;
    if (quo > 128'sd2147483647) return {1'b0, {(CB-1){1'b1}}};
    if (quo < -128'sd2147483648) return {1'b1, {(CB-1){1'b0}}};
    return quo[CB-1:0];
  endfunction

  // Center of the clockwise arc from the stored start point to the given end;
  // advance the start point.
  function automatic arc_center_t arc_center(arc_cmd_t cmd);
    logic signed [127:0] dx, dy, sx, sy, d2, r4, chord, half_h, nx, ny;
    arc_center_t c;
    logic short;
    dx = cmd.end_x - start_x;
    dy = cmd.end_y - start_y;
    sx = cmd.end_x + start_x;
    sy = cmd.end_y + start_y;
    d2 = dx * dx + dy * dy;
    r4 = {97'd0, cmd.radius};
    r4 = (r4 * r4) << 2;
    short  = (d2 != 0) && (r4 < d2);
    chord  = (d2 == 0) ? 128'sd1 : $signed(floor_root(d2));
    half_h = (short || d2 == 0) ? 128'sd0 : $signed(floor_root(r4 - d2));
    nx = sx * chord + dy * half_h + chord;
    ny = sy * chord - dx * half_h + chord;
    c.center_x         = floor_div_clamp(nx, chord * 2);
    c.center_y         = floor_div_clamp(ny, chord * 2);
    c.radius_too_small = short;
    start_x = cmd.end_x;
    start_y = cmd.end_y;
    return c;
  endfunction

  // Driver: present queued words, idle in random bursts.
  int  drv_gap;
  bit  drv_fire;
  logic next_valid;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      drv_gap <= 0;
    end else begin
      drv_fire   = cmd_ch.valid && cmd_ch.ready;
      next_valid = cmd_ch.valid;
      if (drv_fire) begin
        arc_cmd_t acc;
        acc.end_x  = cmd_ch.end_x;
        acc.end_y  = cmd_ch.end_y;
        acc.radius = cmd_ch.radius;
        if (acc.end_x == start_x && acc.end_y == start_y) n_coincident++;
        expected_centers.push_back(arc_center(acc));
        n_sent++;
      end
      if (!cmd_ch.valid || drv_fire) begin
        next_valid = 1'b0;
        if (drv_gap > 0) begin
          drv_gap <= drv_gap - 1;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
          // hold off for a burst
          drv_gap <= $urandom_range(1, 6) - 1;
        end else if (pending_cmds.size() > 0) begin
          arc_cmd_t nxt;
          nxt = pending_cmds.pop_front();
          cmd_ch.end_x  <= nxt.end_x;
          cmd_ch.end_y  <= nxt.end_y;
          cmd_ch.radius <= nxt.radius;
          next_valid = 1'b1;
        end
      end
      cmd_ch.valid <= next_valid;
    end
  end

  // Monitor: stall the sink in random bursts, compare each center word.
  int mon_stall;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      mon_stall <= 0;
    end else begin
      if (center_ch.valid && center_ch.ready) begin
        n_centers++;
        if (expected_centers.size() == 0) begin
          $error("center word with nothing expected: x=%0d y=%0d",
                 center_ch.center_x, center_ch.center_y);
          n_failures++;
        end else begin
          arc_center_t want;
          want = expected_centers.pop_front();
          if (want.radius_too_small) n_too_small++;
          if (center_ch.center_x !== want.center_x) begin
            $error("center_x: expected %0d, got %0d", want.center_x, center_ch.center_x);
            n_failures++;
          end
          if (center_ch.center_y !== want.center_y) begin
            $error("center_y: expected %0d, got %0d", want.center_y, center_ch.center_y);
            n_failures++;
          end
          if (center_ch.radius_too_small !== want.radius_too_small) begin
            $error("radius_too_small: expected %0b, got %0b",
                   want.radius_too_small, center_ch.radius_too_small);
            n_failures++;
          end
        end
      end
      if (mon_stall > 0) begin
        mon_stall <= mon_stall - 1;
        center_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        mon_stall <= $urandom_range(1, 6) - 1;
        center_ch.ready <= 1'b0;
      end else begin
        center_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  int idle_cycles;

  always @(posedge clk) begin
    if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (center_ch.valid && center_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", HANG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Queue one arc; gen_x/gen_y track the start point in generation order.
  logic signed [CB-1:0] gen_x;
  logic signed [CB-1:0] gen_y;

  task automatic queue_arc(logic signed [CB-1:0] ex, logic signed [CB-1:0] ey,
                           logic [CB-1:0] r);
    arc_cmd_t c;
    c.end_x  = ex;
    c.end_y  = ey;
    c.radius = r[CB-2:0];
    pending_cmds.push_back(c);
    gen_x = ex;
    gen_y = ey;
  endtask

  // Half chord length from the current start point to (ex, ey), truncated.
  function automatic logic [127:0] half_chord(logic signed [CB-1:0] ex,
                                              logic signed [CB-1:0] ey);
    logic signed [127:0] dx, dy;
    dx = ex - gen_x;
    dy = ey - gen_y;
    return floor_root(dx * dx + dy * dy) >> 1;
  endfunction

  // Pick a radius for an arc ending at (ex, ey): mostly valid arcs.
  function automatic logic [CB-2:0] pick_radius(logic signed [CB-1:0] ex,
                                                logic signed [CB-1:0] ey);
    logic [127:0] h;
    logic [127:0] r;
    int mode;
    h    = half_chord(ex, ey);
    mode = $urandom_range(0, 9);
    if (mode == 0) r = {$urandom()} & 32'h7fff_ffff;
    else if (mode == 1) r = (h == 0) ? 0 : h - $urandom_range(0, 3);
    else if (mode == 2) r = h + 1;
    else if (mode == 3) r = (h == 0) ? 0 : $urandom_range(0, 32'hffff_ffff) % h;
    else r = h + $urandom_range(0, 32'h0040_0000);
    if (r > 128'h7fff_ffff) r = 128'h7fff_ffff;
    return r[CB-2:0];
  endfunction

  localparam logic signed [CB-1:0] CMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] CMIN = {1'b1, {(CB-1){1'b0}}};
  localparam logic [CB-1:0]        RMAX = {1'b0, {(CB-1){1'b1}}};
  localparam logic signed [CB-1:0] ONE  = 1 <<< FB;

  initial begin
    logic signed [CB-1:0] ex, ey;
    rst_n            = 1'b0;
    cmd_ch.valid     = 1'b0;
    cmd_ch.end_x     = '0;
    cmd_ch.end_y     = '0;
    cmd_ch.radius    = '0;
    center_ch.ready  = 1'b0;
    start_x          = 4 * ONE;
    start_y          = 4 * ONE;
    gen_x            = 4 * ONE;
    gen_y            = 4 * ONE;
    n_failures       = 0;
    n_sent           = 0;
    n_centers        = 0;
    n_too_small      = 0;
    n_coincident     = 0;
    calm             = 1'b0;
    idle_cycles      = 0;

    // Directed arcs: coincident point, half circle, radius just short,
    // zero and full-scale radius, extreme coordinates and a clamped center.
    queue_arc(4 * ONE, 4 * ONE, 5 * ONE);           // same as reset point
    queue_arc(4 * ONE, 8 * ONE, 2 * ONE);           // exact half circle
    queue_arc(8 * ONE, 8 * ONE, 2 * ONE - 1);       // radius just below half chord
    queue_arc(8 * ONE, 0, 0);                       // zero radius
    queue_arc(0, 0, RMAX);                          // largest radius, center far away
    queue_arc(CMAX, CMAX, RMAX);
    queue_arc(CMIN, CMIN, RMAX);                    // longest chord, radius too small
    queue_arc(CMIN, CMIN, 0);                       // coincident with zero radius
    queue_arc(CMAX, CMIN, RMAX);
    queue_arc(CMIN, CMAX, RMAX);
    queue_arc(CMAX, 32'sd0, RMAX);
    queue_arc(-ONE, -ONE, RMAX);
    queue_arc(ONE, -ONE, RMAX);                     // huge radius, short chord: clamps
    queue_arc(-ONE, ONE, 3 * ONE);
    queue_arc(-ONE, ONE, 1);                        // coincident, tiny radius
    queue_arc(0, 0, 1);
    queue_arc(1, 0, 1);                             // one LSB chord
    queue_arc(1, 1, 0);
    queue_arc(-5 * ONE, 7 * ONE, RMAX);
    queue_arc(3 * ONE, -2 * ONE, CB'(half_chord(3 * ONE, -2 * ONE)));

    // Random arcs: mostly moderate moves with well-formed radii, some full-range noise.
    for (int i = 0; i < N_RANDOM; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          ex = $urandom();
          ey = $urandom();
        end
        1: begin
          ex = gen_x;
          ey = gen_y;
        end
        default: begin
          ex = gen_x + $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
          ey = gen_y + $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
          // drift back toward the origin so the path stays in range
          if (gen_x > 32'sh2000_0000 || gen_x < -32'sh2000_0000) ex = ex >>> 1;
          if (gen_y > 32'sh2000_0000 || gen_y < -32'sh2000_0000) ey = ey >>> 1;
        end
      endcase
      queue_arc(ex, ey, {1'b0, pick_radius(ex, ey)});
    end
    n_total = pending_cmds.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drop idling once the last stretch of words is being driven.
    while (pending_cmds.size() > CALM_TAIL) @(posedge clk);
    calm = 1'b1;
    while (pending_cmds.size() > 0 || cmd_ch.valid) @(posedge clk);
    while (expected_centers.size() > 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);

    $display("covered %0d arcs, %0d centers checked: %0d radius-too-small, %0d coincident",
             n_sent, n_centers, n_too_small, n_coincident);
    if (n_failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", n_failures);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/cacfr_pkg.sv
rtl/cacfr_if.sv
rtl/cacfr_ctrl.sv
rtl/cacfr_dp.sv
rtl/clockwise_arc_center_from_radius_top.sv
rtl/cacfr_chk.sv
test/clockwise_arc_center_from_radius_top_test.sv
